// File: design/hrfw_pkg.sv
// ----------------------------------------------------------------------------
// hrfw_pkg
// Shared types and constants of the HEX record flash writer.
// ----------------------------------------------------------------------------
package hrfw_pkg;

    localparam int MAX_DATA_BYTES_DEF = 255;

    localparam logic [31:0] KSEG0_OFFSET = 32'h8000_0000;
    localparam logic [31:0] PAD_WORD     = 32'hFFFF_FFFF;

    localparam int CFG_INDEX_W = 8;

    // reset values of the window registers
    localparam logic [31:0] APP_LOW_RST      = 32'd2634022912;
    localparam logic [31:0] APP_HIGH_RST     = 32'd2634153983;
    localparam logic [31:0] PROTECT_LOW_RST  = 32'd2680172528;
    localparam logic [31:0] PROTECT_HIGH_RST = 32'd2680172543;

    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_NEXT  = 2'd1,
        OP_FAIL  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_APP_LOW      = 8'd0,
        REG_APP_HIGH     = 8'd1,
        REG_PROTECT_LOW  = 8'd2,
        REG_PROTECT_HIGH = 8'd3
    } cfg_reg_t;

    // record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_SEG  = 8'h02;
    localparam logic [7:0] REC_LIN  = 8'h04;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [31:0] word;
        logic        error;
        logic        saved_ok;
        logic [31:0] words_written;
        logic        last;
    } res_t;

endpackage

// File: design/hrfw_if.sv
// ----------------------------------------------------------------------------
// hrfw channel interfaces
// Record byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface hrfw_rec_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface hrfw_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] address;
    logic [31:0] word;
    logic        error;
    logic        saved_ok;
    logic [31:0] words_written;
    logic        last;

    modport source (output valid, output kind, output address, output word, output error,
                    output saved_ok, output words_written, output last, input ready);
    modport sink (input valid, input kind, input address, input word, input error,
                  input saved_ok, input words_written, input last, output ready);
endinterface

interface hrfw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hrfw_pkg::CFG_INDEX_W-1:0] index;
    logic [31:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/hrfw_ram.sv
// ----------------------------------------------------------------------------
// hrfw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/hex_record_flash_writer_core.sv
// ----------------------------------------------------------------------------
// hex_record_flash_writer_core
// Collects Intel HEX record bytes, checks the record sum and turns data
// records into 32-bit flash word writes inside the application window and outside the protected range.
// Flow: a byte that does not close a record, and ops 2 and 3, give a registered
//   status result via ST_STATUS, held off by a full output; new bytes wait for idle.
// Record close: data records walk the buffer RAM through ST_WADDR and ST_WDATA per
//   byte (registered read), then ST_WPUSH per in-window word; ST_WCHK skips words
//   outside the window. Base records pass ST_BASE0, ST_BASE1 and ST_BASE2. No clearing pass after reset.
// Reset: async, active low; clears all control state, restores the windows.
// ----------------------------------------------------------------------------
module hex_record_flash_writer_core #(
    parameter int MAX_DATA_BYTES = hrfw_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    hrfw_rec_if.sink       rec,
    hrfw_res_if.source     res,
    hrfw_cfg_if.sink       cfg
);

    localparam int ADDR_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STATUS,
        ST_WCHK,
        ST_WADDR,
        ST_WDATA,
        ST_WPUSH,
        ST_WEND,
        ST_BASE0,
        ST_BASE1,
        ST_BASE2
    } state_t;

    // ------------------------------------------------------------------
    // window registers
    // ------------------------------------------------------------------
    logic [31:0] app_low_reg, app_high_reg, prot_low_reg, prot_high_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_low_reg   <= hrfw_pkg::APP_LOW_RST;
            app_high_reg  <= hrfw_pkg::APP_HIGH_RST;
            prot_low_reg  <= hrfw_pkg::PROTECT_LOW_RST;
            prot_high_reg <= hrfw_pkg::PROTECT_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            case (hrfw_pkg::cfg_reg_t'(cfg.index))
                hrfw_pkg::REG_APP_LOW:      app_low_reg   <= cfg.data;
                hrfw_pkg::REG_APP_HIGH:     app_high_reg  <= cfg.data;
                hrfw_pkg::REG_PROTECT_LOW:  prot_low_reg  <= cfg.data;
                hrfw_pkg::REG_PROTECT_HIGH: prot_high_reg <= cfg.data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t          state_reg;
    logic [8:0]      pos_reg;        // byte position in record
    logic [7:0]      len_reg;
    logic [7:0]      rkind_reg;
    logic [15:0]     off_reg;
    logic [7:0]      sum_reg;
    logic [19:0]     seg_reg;
    logic [31:0]     lin_reg;
    logic            err_reg;
    logic            done_reg;
    logic [31:0]     wc_reg;

    // word walk
    logic [31:0]     va_reg;
    logic [7:0]      rem_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [1:0]      bcnt_reg;
    logic [31:0]     cur_word_reg;
    logic [7:0]      b0_reg;

    // one result held back so the final one can carry last
    logic            pend_valid_reg;
    logic [31:0]     pend_addr_reg;
    logic [31:0]     pend_word_reg;
    logic [31:0]     pend_count_reg;

    hrfw_pkg::res_t  out_reg;
    logic            out_valid_reg;

    // ------------------------------------------------------------------
    // byte decode
    // ------------------------------------------------------------------
    hrfw_pkg::op_t   op;
    logic            accept;
    logic            is_byte;
    logic [8:0]      pos;
    logic [8:0]      end_pos;
    logic [8:0]      widx;
    logic [7:0]      sum_next;
    logic            finish;
    logic            store;
    logic            bad;
    logic [31:0]     base_va;

    assign rec.ready = (state_reg == ST_IDLE);
    assign accept    = rec.valid && rec.ready;
    assign op        = hrfw_pkg::op_t'(rec.op);
    assign is_byte   = (op == hrfw_pkg::OP_FIRST) || (op == hrfw_pkg::OP_NEXT);
    assign pos       = (op == hrfw_pkg::OP_FIRST) ? 9'd0 : pos_reg;
    assign end_pos   = {1'b0, len_reg} + 9'd4;
    assign widx      = pos - 9'd4;
    assign sum_next  = ((pos == 9'd0) ? 8'd0 : sum_reg) + rec.value;
    assign finish    = (pos >= 9'd4) && (pos == end_pos);
    assign store     = (pos >= 9'd4) && (pos < end_pos) && (widx < 9'(MAX_DATA_BYTES));
    assign bad       = (sum_next != 8'd0) || ({1'b0, len_reg} > 9'(MAX_DATA_BYTES));
    assign base_va   = {16'd0, off_reg} + lin_reg + {12'd0, seg_reg} + hrfw_pkg::KSEG0_OFFSET;

    // ------------------------------------------------------------------
    // word walk helpers
    // ------------------------------------------------------------------
    logic            in_win;
    logic [1:0]      last_lane;
    logic            out_free;
    logic [31:0]     va_adv;
    logic [ADDR_W-1:0] idx_adv;
    logic [7:0]      rem_adv;
    logic [31:0]     wc_inc;

    assign in_win    = (va_reg >= app_low_reg) && (va_reg <= app_high_reg) &&
                       ((va_reg < prot_low_reg) || (va_reg > prot_high_reg));
    assign last_lane = (rem_reg < 8'd4) ? (rem_reg[1:0] - 2'd1) : 2'd3;
    assign out_free  = !out_valid_reg || res.ready;
    assign va_adv    = va_reg + 32'd4;
    assign idx_adv   = idx_reg + ADDR_W'(4);
    assign rem_adv   = (rem_reg > 8'd3) ? (rem_reg - 8'd4) : 8'd0;
    assign wc_inc    = wc_reg + 32'd1;

    hrfw_pkg::res_t  status_res;
    hrfw_pkg::res_t  pend_res;

    always_comb
    begin
        status_res               = '0;
        status_res.kind          = hrfw_pkg::KIND_STATUS;
        status_res.error         = err_reg;
        status_res.saved_ok      = done_reg;
        status_res.words_written = wc_reg;
        status_res.last          = 1'b1;

        pend_res                 = '0;
        pend_res.kind            = hrfw_pkg::KIND_WRITE;
        pend_res.address         = pend_addr_reg;
        pend_res.word            = pend_word_reg;
        pend_res.error           = err_reg;
        pend_res.saved_ok        = done_reg;
        pend_res.words_written   = pend_count_reg;
        pend_res.last            = 1'b0;
    end

    // ------------------------------------------------------------------
    // data buffer
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    assign ram_we = accept && is_byte && store;

    always_comb
    begin
        case (state_reg)
            ST_BASE0: ram_raddr = '0;
            ST_BASE1: ram_raddr = ADDR_W'(1);
            default:  ram_raddr = idx_reg + ADDR_W'(bcnt_reg);
        endcase
    end

    hrfw_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx[ADDR_W-1:0]),
        .wdata (rec.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            len_reg        <= '0;
            rkind_reg      <= '0;
            off_reg        <= '0;
            sum_reg        <= '0;
            seg_reg        <= '0;
            lin_reg        <= '0;
            err_reg        <= 1'b0;
            done_reg       <= 1'b0;
            wc_reg         <= '0;
            va_reg         <= '0;
            rem_reg        <= '0;
            idx_reg        <= '0;
            bcnt_reg       <= '0;
            cur_word_reg   <= '0;
            b0_reg         <= '0;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
            pend_word_reg  <= '0;
            pend_count_reg <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_STATUS;
                        case (op)
                            hrfw_pkg::OP_FAIL:
                            begin
                                err_reg <= 1'b1;
                            end
                            hrfw_pkg::OP_CLEAR:
                            begin
                                err_reg  <= 1'b0;
                                done_reg <= 1'b0;
                            end
                            default:
                            begin
                                sum_reg <= sum_next;
                                case (pos)
                                    9'd0:    len_reg        <= rec.value;
                                    9'd1:    off_reg[15:8]  <= rec.value;
                                    9'd2:    off_reg[7:0]   <= rec.value;
                                    9'd3:    rkind_reg      <= rec.value;
                                    default: ;
                                endcase
                                if (finish)
                                begin
                                    pos_reg <= '0;
                                    if (bad)
                                    begin
                                        err_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        case (rkind_reg)
                                            hrfw_pkg::REC_DATA:
                                            begin
                                                va_reg    <= base_va;
                                                rem_reg   <= len_reg;
                                                idx_reg   <= '0;
                                                state_reg <= ST_WCHK;
                                            end
                                            hrfw_pkg::REC_EOF:
                                            begin
                                                seg_reg <= '0;
                                                lin_reg <= '0;
                                                if (!err_reg)
                                                begin
                                                    done_reg <= 1'b1;
                                                end
                                            end
                                            hrfw_pkg::REC_SEG,
                                            hrfw_pkg::REC_LIN:
                                            begin
                                                state_reg <= ST_BASE0;
                                            end
                                            default:
                                            begin
                                                seg_reg <= '0;
                                                lin_reg <= '0;
                                            end
                                        endcase
                                    end
                                end
                                else
                                begin
                                    pos_reg <= pos + 9'd1;
                                end
                            end
                        endcase
                    end
                end

                ST_STATUS:
                begin
                    if (out_free)
                    begin
                        out_reg       <= status_res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                ST_WCHK:
                begin
                    if (rem_reg == 8'd0)
                    begin
                        state_reg <= ST_WEND;
                    end
                    else if (in_win)
                    begin
                        bcnt_reg     <= '0;
                        cur_word_reg <= hrfw_pkg::PAD_WORD;
                        state_reg    <= ST_WADDR;
                    end
                    else
                    begin
                        va_reg  <= va_adv;
                        idx_reg <= idx_adv;
                        rem_reg <= rem_adv;
                    end
                end

                ST_WADDR:
                begin
                    state_reg <= ST_WDATA;
                end

                ST_WDATA:
                begin
                    cur_word_reg[{bcnt_reg, 3'b000} +: 8] <= ram_rdata;
                    if (bcnt_reg == last_lane)
                    begin
                        state_reg <= ST_WPUSH;
                    end
                    else
                    begin
                        bcnt_reg  <= bcnt_reg + 2'd1;
                        state_reg <= ST_WADDR;
                    end
                end

                ST_WPUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg       <= pend_res;
                            out_valid_reg <= 1'b1;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_addr_reg  <= va_reg;
                        pend_word_reg  <= cur_word_reg;
                        pend_count_reg <= wc_inc;
                        wc_reg         <= wc_inc;
                        va_reg         <= va_adv;
                        idx_reg        <= idx_adv;
                        rem_reg        <= rem_adv;
                        state_reg      <= ST_WCHK;
                    end
                end

                ST_WEND:
                begin
                    if (out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg      <= pend_res;
                            out_reg.last <= 1'b1;
                        end
                        else
                        begin
                            out_reg <= status_res;
                        end
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                ST_BASE0:
                begin
                    state_reg <= ST_BASE1;
                end

                ST_BASE1:
                begin
                    b0_reg    <= ram_rdata;
                    state_reg <= ST_BASE2;
                end

                ST_BASE2:
                begin
                    if (rkind_reg == hrfw_pkg::REC_SEG)
                    begin
                        seg_reg <= {b0_reg, ram_rdata, 4'h0};
                        lin_reg <= '0;
                    end
                    else
                    begin
                        lin_reg <= {b0_reg, ram_rdata, 16'h0000};
                        seg_reg <= '0;
                    end
                    state_reg <= ST_STATUS;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.kind          = out_reg.kind;
    assign res.address       = out_reg.address;
    assign res.word          = out_reg.word;
    assign res.error         = out_reg.error;
    assign res.saved_ok      = out_reg.saved_ok;
    assign res.words_written = out_reg.words_written;
    assign res.last          = out_reg.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == hrfw_pkg::KIND_STATUS) |->
            (res.address == 32'd0) && (res.word == 32'd0) && res.last)
        else $error("status result carries address or word");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wc_reg != $past(wc_reg)) |-> (wc_reg == $past(wc_reg) + 32'd1))
        else $error("write count jumped");

    a_saved_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> !$past(err_reg) && !err_reg)
        else $error("saved_ok set while error pending");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        rec.ready |-> !pend_valid_reg)
        else $error("held write left behind at idle");

    a_buf_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("buffer written during record walk");

endmodule
